### rtl/core/bsps_pkg.sv
// ----------------------------------------------------------------------------
// bsps_pkg: shared types and constants of the B-spline path sampler
// Coordinate format, command record between front and back, and the
// reciprocal table used to build the basis weights.
// ----------------------------------------------------------------------------
package bsps_pkg;

    // Coordinate format (signed Q16.16 at the default width)
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Span register
    localparam int SPAN_W     = 5;
    localparam int SPAN_LIMIT = 20;
    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(10);
    localparam logic [SPAN_W-1:0] SPAN_MIN   = SPAN_W'(1);
    localparam logic [SPAN_W-1:0] SPAN_MAX   = SPAN_W'(SPAN_LIMIT);

    // Weight arithmetic
    localparam int WEIGHT_W = FRAC_BITS + 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;
    localparam int SQ_W        = 2 * SPAN_W;
    localparam int NUM_W       = SQ_W + FRAC_BITS;
    localparam int DEN_W       = SQ_W + 1;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 26;
    localparam int NR_W        = NUM_W + RECIP_W;

    // floor(2^RECIP_SHIFT / (2*S*S)) for S = 1..20; entry 0 is never used
    localparam logic [RECIP_W-1:0] RECIP_TABLE [0:SPAN_LIMIT] = '{
        RECIP_W'(0),
        RECIP_W'((2**RECIP_SHIFT) / (2*1*1)),
        RECIP_W'((2**RECIP_SHIFT) / (2*2*2)),
        RECIP_W'((2**RECIP_SHIFT) / (2*3*3)),
        RECIP_W'((2**RECIP_SHIFT) / (2*4*4)),
        RECIP_W'((2**RECIP_SHIFT) / (2*5*5)),
        RECIP_W'((2**RECIP_SHIFT) / (2*6*6)),
        RECIP_W'((2**RECIP_SHIFT) / (2*7*7)),
        RECIP_W'((2**RECIP_SHIFT) / (2*8*8)),
        RECIP_W'((2**RECIP_SHIFT) / (2*9*9)),
        RECIP_W'((2**RECIP_SHIFT) / (2*10*10)),
        RECIP_W'((2**RECIP_SHIFT) / (2*11*11)),
        RECIP_W'((2**RECIP_SHIFT) / (2*12*12)),
        RECIP_W'((2**RECIP_SHIFT) / (2*13*13)),
        RECIP_W'((2**RECIP_SHIFT) / (2*14*14)),
        RECIP_W'((2**RECIP_SHIFT) / (2*15*15)),
        RECIP_W'((2**RECIP_SHIFT) / (2*16*16)),
        RECIP_W'((2**RECIP_SHIFT) / (2*17*17)),
        RECIP_W'((2**RECIP_SHIFT) / (2*18*18)),
        RECIP_W'((2**RECIP_SHIFT) / (2*19*19)),
        RECIP_W'((2**RECIP_SHIFT) / (2*20*20))
    };

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // One unit of work for the back: a window (a,b,c) or a single pass point
    typedef struct packed {
        point_t a;
        point_t b;
        point_t c;
        logic   pass;
        logic   run_last;
        logic   path_last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

endpackage

### rtl/core/bsps_if.sv
// ----------------------------------------------------------------------------
// bsps_if: stream and configuration channels of the path sampler
// Valid/ready channels for control points, curve samples and the span
// register write.
// ----------------------------------------------------------------------------
interface bsps_point_if;
    import bsps_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   path_end_in;

    modport source (output valid, output point_x, output point_y, output path_end_in,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input path_end_in,
                  output ready);
endinterface

interface bsps_sample_if;
    import bsps_pkg::*;

    logic   valid;
    logic   ready;
    coord_t curve_x;
    coord_t curve_y;
    logic   run_last;
    logic   path_last;

    modport source (output valid, output curve_x, output curve_y, output run_last,
                    output path_last, input ready);
    modport sink (input valid, input curve_x, input curve_y, input run_last,
                  input path_last, output ready);
endinterface

interface bsps_cfg_if;
    import bsps_pkg::*;

    logic              valid;
    logic              ready;
    logic [SPAN_W-1:0] samples_per_span;

    modport source (output valid, output samples_per_span, input ready);
    modport sink (input valid, input samples_per_span, output ready);
endinterface

### rtl/core/quadratic_bspline_path_sampler.sv
// ----------------------------------------------------------------------------
// quadratic_bspline_path_sampler: uniform quadratic B-spline path sampling
// A point's commands pass through the queue and then the back's register stages.
// Throughput: one sample per cycle from the back's counter unless the output stalls:
// S+1 samples a point, 2*(S+1) for the last point of a path of three or more, none
// for a path's first point, 1 for a one-point path, 2 for the end of a two-point path.
// Reset: rst_n clears the path state, queue and pipeline; span returns to 10.
// ----------------------------------------------------------------------------
module quadratic_bspline_path_sampler (
    input  logic           clk,
    input  logic           rst_n,
    bsps_point_if.sink     points,
    bsps_sample_if.source  samples,
    bsps_cfg_if.sink       cfg
);
    import bsps_pkg::*;

    logic [SPAN_W-1:0] span_reg;
    cmd_beat_t         q_push;
    cmd_beat_t         q_head;
    logic              q_full;
    logic              q_pop;

    // span register write
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_reg <= SPAN_RESET;
        else if (cfg.valid && cfg.ready)
            span_reg <= cfg.samples_per_span;
    end

    bsps_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points),
        .q_full (q_full),
        .q_push (q_push)
    );

    bsps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full)
    );

    bsps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .span    (span_reg),
        .head    (q_head),
        .pop     (q_pop),
        .samples (samples)
    );

    // front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> !q_full)
        else $error("command pushed into full queue");

    // a point is only taken when the queue has room
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        points.ready |-> !q_full)
        else $error("point ready with full queue");

    // back pops only a present command
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("pop from empty queue");

    // end of path always closes a run
    a_path_run: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.path_last) |-> samples.run_last)
        else $error("path_last without run_last");

endmodule

### rtl/core/bsps_front.sv
// ----------------------------------------------------------------------------
// bsps_front: point intake and window classification
// Keeps the last two points of the path, doubles the end points and turns
// each accepted point into zero, one or two commands for the back.
// ----------------------------------------------------------------------------
module bsps_front (
    input  logic                clk,
    input  logic                rst_n,
    bsps_point_if.sink          points,
    input  logic                q_full,
    output bsps_pkg::cmd_beat_t q_push
);
    import bsps_pkg::*;

    // points seen so far in the current path, saturating
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_MANY = 2'd3;

    logic [1:0] seen_reg, seen_next;
    point_t     older_reg, older_next;
    point_t     newer_reg, newer_next;
    logic       hold_valid_reg, hold_valid_next;
    cmd_t       hold_cmd_reg, hold_cmd_next;

    point_t p;
    logic   last;
    logic   accept;
    logic   has_first, has_second;
    cmd_t   first_cmd, second_cmd;

    assign p      = '{x: points.point_x, y: points.point_y};
    assign last   = points.path_end_in;
    assign points.ready = !hold_valid_reg && !q_full;
    assign accept = points.valid && points.ready;

    // classify the incoming point
    always_comb
    begin
        has_first  = 1'b0;
        has_second = 1'b0;
        first_cmd  = '{a: p, b: p, c: p, pass: 1'b1, run_last: 1'b1, path_last: last};
        second_cmd = '{a: p, b: p, c: p, pass: 1'b1, run_last: 1'b1, path_last: 1'b1};
        unique case (seen_reg)
            SEEN_NONE:
            begin
                has_first = last;
            end
            SEEN_ONE:
            begin
                has_first = 1'b1;
                if (last)
                begin
                    // two-point path: both points go out unchanged
                    first_cmd  = '{a: newer_reg, b: newer_reg, c: newer_reg, pass: 1'b1,
                                   run_last: 1'b0, path_last: 1'b0};
                    has_second = 1'b1;
                end
                else
                begin
                    first_cmd = '{a: newer_reg, b: newer_reg, c: p, pass: 1'b0,
                                  run_last: 1'b1, path_last: 1'b0};
                end
            end
            default:
            begin
                has_first  = 1'b1;
                first_cmd  = '{a: older_reg, b: newer_reg, c: p, pass: 1'b0,
                               run_last: !last, path_last: 1'b0};
                has_second = last;
                // closing window with the end point doubled
                second_cmd = '{a: newer_reg, b: p, c: p, pass: 1'b0,
                               run_last: 1'b1, path_last: 1'b1};
            end
        endcase
    end

    // queue push: a held second command goes first
    always_comb
    begin
        if (hold_valid_reg)
        begin
            q_push.valid = !q_full;
            q_push.cmd   = hold_cmd_reg;
        end
        else
        begin
            q_push.valid = accept && has_first;
            q_push.cmd   = first_cmd;
        end
    end

    // next state
    always_comb
    begin
        seen_next       = seen_reg;
        older_next      = older_reg;
        newer_next      = newer_reg;
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (hold_valid_reg && !q_full)
            hold_valid_next = 1'b0;
        if (accept)
        begin
            if (has_second)
            begin
                hold_valid_next = 1'b1;
                hold_cmd_next   = second_cmd;
            end
            if (last)
                seen_next = SEEN_NONE;
            else
            begin
                older_next = newer_reg;
                newer_next = p;
                seen_next  = (seen_reg == SEEN_MANY) ? SEEN_MANY : seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= SEEN_NONE;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        older_reg    <= older_next;
        newer_reg    <= newer_next;
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

### rtl/core/bsps_queue.sv
// ----------------------------------------------------------------------------
// bsps_queue: short command FIFO between front and back
// Register-based ring of QUEUE_DEPTH commands with a fill count.
// ----------------------------------------------------------------------------
module bsps_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  bsps_pkg::cmd_beat_t push,
    input  logic                pop,
    output bsps_pkg::cmd_beat_t head,
    output logic                full
);
    import bsps_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.cmd;
    end

endmodule

### rtl/core/bsps_back.sv
// ----------------------------------------------------------------------------
// bsps_back: curve sample generator
// Steps j = 0..S over the head command (only j = 0 for a pass point), builds the
// basis weights with a reciprocal multiply and one correction, blends the three
// control points and saturates. Six register stages, stalled as a whole by the output.
// ----------------------------------------------------------------------------
module bsps_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [bsps_pkg::SPAN_W-1:0] span,
    input  bsps_pkg::cmd_beat_t   head,
    output logic                  pop,
    bsps_sample_if.source         samples
);
    import bsps_pkg::*;

    localparam int MUL_W = WEIGHT_W + 1 + COORD_WIDTH;
    localparam int ACC_W = MUL_W + 2;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        point_t a;
        point_t b;
        point_t c;
        logic   pass;
        logic   run_last;
        logic   path_last;
    } tag_t;

    // span clamp and derived constants
    logic [SPAN_W-1:0]  s_eff;
    logic [SQ_W-1:0]    span_sq;
    logic [DEN_W-1:0]   den;
    logic [RECIP_W-1:0] recip;

    always_comb
    begin
        if (span < SPAN_MIN)
            s_eff = SPAN_MIN;
        else if (span > SPAN_MAX)
            s_eff = SPAN_MAX;
        else
            s_eff = span;
    end

    assign span_sq = {{SPAN_W{1'b0}}, s_eff} * {{SPAN_W{1'b0}}, s_eff};
    assign den     = {span_sq, 1'b0};
    assign recip   = RECIP_TABLE[s_eff];

    // pipeline advance
    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || samples.ready;

    // issue: sample counter over the head command
    logic [SPAN_W-1:0] j_reg, j_next;
    logic [SPAN_W-1:0] j_max, jc;
    logic              issue, last_of_cmd;
    logic [SQ_W-1:0]   sq0, sq2;
    tag_t              tag0;

    assign j_max       = head.cmd.pass ? '0 : s_eff;
    assign last_of_cmd = (j_reg == j_max);
    assign issue       = en && head.valid;
    assign pop         = issue && last_of_cmd;
    assign jc          = s_eff - j_reg;
    assign sq0         = {{SPAN_W{1'b0}}, jc} * {{SPAN_W{1'b0}}, jc};
    assign sq2         = {{SPAN_W{1'b0}}, j_reg} * {{SPAN_W{1'b0}}, j_reg};
    assign tag0        = '{a: head.cmd.a, b: head.cmd.b, c: head.cmd.c, pass: head.cmd.pass,
                           run_last: head.cmd.run_last && last_of_cmd,
                           path_last: head.cmd.path_last && last_of_cmd};

    always_comb
    begin
        j_next = j_reg;
        if (issue)
            j_next = last_of_cmd ? '0 : j_reg + SPAN_W'(1);
    end

    // stage registers
    logic                        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    tag_t                        t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [NUM_W-1:0]            n0_1_reg, n2_1_reg, n0_2_reg, n2_2_reg, n0_3_reg, n2_3_reg;
    logic [NR_W-1:0]             p0_2_reg, p2_2_reg;
    logic [WEIGHT_W-1:0]         q0_3_reg, q2_3_reg;
    logic [NUM_W-1:0]            m0_3_reg, m2_3_reg;
    logic [WEIGHT_W-1:0]         w0_4_reg, w1_4_reg, w2_4_reg;
    logic signed [MUL_W-1:0]     px0_reg, px1_reg, px2_reg, py0_reg, py1_reg, py2_reg;
    coord_t                      curve_x_reg, curve_y_reg;
    logic                        run_last_reg, path_last_reg;

    // stage 3 quotient estimates, stage 4 corrected weights
    logic [WEIGHT_W-1:0] q0_est, q2_est;
    logic [NUM_W-1:0]    r0, r2;
    logic [WEIGHT_W-1:0] w0, w2, w1;

    assign q0_est = p0_2_reg[RECIP_SHIFT +: WEIGHT_W];
    assign q2_est = p2_2_reg[RECIP_SHIFT +: WEIGHT_W];
    assign r0     = n0_3_reg - m0_3_reg;
    assign r2     = n2_3_reg - m2_3_reg;

    always_comb
    begin
        w0 = (r0 >= NUM_W'(den)) ? q0_3_reg + WEIGHT_W'(1) : q0_3_reg;
        w2 = (r2 >= NUM_W'(den)) ? q2_3_reg + WEIGHT_W'(1) : q2_3_reg;
        // a pass point takes the middle control point whole
        if (t3_reg.pass)
        begin
            w0 = '0;
            w2 = '0;
        end
        w1 = WEIGHT_ONE - w0 - w2;
    end

    // stage 6 blend, round and saturate
    logic signed [ACC_W-1:0] acc_x, acc_y, sh_x, sh_y;
    coord_t                  sat_x, sat_y;

    assign acc_x = ACC_W'(px0_reg) + ACC_W'(px1_reg) + ACC_W'(px2_reg) + ROUND_HALF;
    assign acc_y = ACC_W'(py0_reg) + ACC_W'(py1_reg) + ACC_W'(py2_reg) + ROUND_HALF;
    assign sh_x  = acc_x >>> FRAC_BITS;
    assign sh_y  = acc_y >>> FRAC_BITS;

    always_comb
    begin
        if (sh_x > SAT_MAX)
            sat_x = SAT_MAX[COORD_WIDTH-1:0];
        else if (sh_x < SAT_MIN)
            sat_x = SAT_MIN[COORD_WIDTH-1:0];
        else
            sat_x = sh_x[COORD_WIDTH-1:0];
        if (sh_y > SAT_MAX)
            sat_y = SAT_MAX[COORD_WIDTH-1:0];
        else if (sh_y < SAT_MIN)
            sat_y = SAT_MIN[COORD_WIDTH-1:0];
        else
            sat_y = sh_y[COORD_WIDTH-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            j_reg <= j_next;
            if (en)
            begin
                v1_reg        <= issue;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                out_valid_reg <= v5_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: weight numerators
            t1_reg   <= tag0;
            n0_1_reg <= {sq0, {FRAC_BITS{1'b0}}} + NUM_W'(span_sq);
            n2_1_reg <= {sq2, {FRAC_BITS{1'b0}}} + NUM_W'(span_sq);
            // stage 2: reciprocal products
            t2_reg   <= t1_reg;
            n0_2_reg <= n0_1_reg;
            n2_2_reg <= n2_1_reg;
            p0_2_reg <= NR_W'(n0_1_reg) * NR_W'(recip);
            p2_2_reg <= NR_W'(n2_1_reg) * NR_W'(recip);
            // stage 3: back-multiply for the remainder
            t3_reg   <= t2_reg;
            n0_3_reg <= n0_2_reg;
            n2_3_reg <= n2_2_reg;
            q0_3_reg <= q0_est;
            q2_3_reg <= q2_est;
            m0_3_reg <= NUM_W'(q0_est) * NUM_W'(den);
            m2_3_reg <= NUM_W'(q2_est) * NUM_W'(den);
            // stage 4: corrected weights
            t4_reg   <= t3_reg;
            w0_4_reg <= w0;
            w1_4_reg <= w1;
            w2_4_reg <= w2;
            // stage 5: weighted coordinates
            t5_reg   <= t4_reg;
            px0_reg  <= $signed({1'b0, w0_4_reg}) * t4_reg.a.x;
            px1_reg  <= $signed({1'b0, w1_4_reg}) * t4_reg.b.x;
            px2_reg  <= $signed({1'b0, w2_4_reg}) * t4_reg.c.x;
            py0_reg  <= $signed({1'b0, w0_4_reg}) * t4_reg.a.y;
            py1_reg  <= $signed({1'b0, w1_4_reg}) * t4_reg.b.y;
            py2_reg  <= $signed({1'b0, w2_4_reg}) * t4_reg.c.y;
            // stage 6: output beat
            curve_x_reg   <= sat_x;
            curve_y_reg   <= sat_y;
            run_last_reg  <= t5_reg.run_last;
            path_last_reg <= t5_reg.path_last;
        end
    end

    assign samples.valid     = out_valid_reg;
    assign samples.curve_x   = curve_x_reg;
    assign samples.curve_y   = curve_y_reg;
    assign samples.run_last  = run_last_reg;
    assign samples.path_last = path_last_reg;

endmodule
